// File: rtl/knn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_pkg: shared types and constants of the k-nearest insertion list
// Holds the channel payloads, the list entry, the per-cell control and
// status groups, and the state encoding of the result sequencer.
// ----------------------------------------------------------------------------
package knn_pkg;

  localparam int DIST_W  = 32;
  localparam int LABEL_W = 16;
  localparam int POS_W   = 5;
  localparam int K_W     = 5;

  localparam logic [DIST_W-1:0]         DIST_INF   = '1;
  localparam logic signed [LABEL_W-1:0] LABEL_NONE = -16'sd1;

  typedef struct packed {
    logic [DIST_W-1:0]         distance;
    logic signed [LABEL_W-1:0] label;
  } entry_t;

  typedef struct packed {
    logic [DIST_W-1:0]         cand_distance;
    logic signed [LABEL_W-1:0] cand_label;
    logic                      first_of_set;
    logic                      last_of_set;
  } in_payload_t;

  typedef struct packed {
    logic                      kind;
    logic [POS_W-1:0]          position;
    logic [DIST_W-1:0]         out_distance;
    logic signed [LABEL_W-1:0] out_label;
    logic                      last_result;
  } out_payload_t;

  typedef struct packed {
    logic [K_W-1:0] k_in_use;
  } cfg_payload_t;

  // Result kinds.
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  // Broadcast control for every cell of the chain.
  typedef struct packed {
    logic load;   // an item is accepted this cycle
    logic first;  // that item opens a new set
    logic emit;   // rotate the active entries one place toward the head
  } cell_ctl_t;

  // Per-cell status handed back to the top level.
  typedef struct packed {
    logic hit_out;   // this cell or one before it holds a greater distance
    logic hit_here;  // this cell is the insertion place
  } cell_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/knn_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_stream_if: valid/ready channel with a typed payload
// Used for the input, result and configuration channels of the block.
// ----------------------------------------------------------------------------
interface knn_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/k_nearest_sorted_insert_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_nearest_sorted_insert_top: sorted list of the k nearest candidates
// Keeps the k smallest candidate distances of a set with their labels.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one candidate item per handshake: distance, label and the
//   first-of-set / last-of-set flags. cfg_ch writes k_in_use; it is taken
//   only while no list readout is in progress. out_ch carries results.
//   Every item yields one insertion report in the cycle after it is accepted.
//   An item with last_of_set then yields the k kept entries, one per cycle
//   while the receiver takes them; after any other item the next item may
//   follow right behind it. The readout rate is set by the chain of cells,
//   which rotates its active entries one place per cycle toward the head
//   cell that feeds the result register, as long as that register is free.
//   A single result register decouples the two sides: a new item is
//   accepted while the previous report waits, provided the receiver takes
//   it in the same cycle. When the receiver stalls, the result holds and
//   the chain stops. Synchronous reset fills every place with infinity and
//   label -1 and sets k_in_use to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module k_nearest_sorted_insert_top #(
  parameter int MAX_NEIGHBORS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  knn_stream_if.sink   in_ch,
  knn_stream_if.source out_ch,
  knn_stream_if.sink   cfg_ch
);

  knn_pkg::state_t       state_r;
  knn_pkg::state_t       state_nxt;
  logic [knn_pkg::K_W-1:0]   k_r;
  logic [knn_pkg::K_W-1:0]   k_eff;
  logic [knn_pkg::POS_W-1:0] emit_idx_r;
  logic [knn_pkg::POS_W-1:0] emit_idx_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  knn_pkg::out_payload_t out_data_r;
  knn_pkg::out_payload_t out_data_nxt;

  logic                  out_free;
  logic                  in_fire;
  logic                  cfg_fire;
  logic                  emit_last;
  knn_pkg::cell_ctl_t    ctl;
  knn_pkg::entry_t       cand;

  knn_pkg::entry_t       eff_entry [MAX_NEIGHBORS];
  knn_pkg::entry_t       entry     [MAX_NEIGHBORS];
  knn_pkg::cell_stat_t   stat      [MAX_NEIGHBORS];
  logic [MAX_NEIGHBORS-1:0] hit_here;
  logic [knn_pkg::POS_W-1:0] place_enc;
  logic [knn_pkg::POS_W-1:0] place;

  // Handshakes. Configuration is held off during a readout so that the
  // entry count cannot change under the sequencer.
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == knn_pkg::ST_IDLE) && out_free;
  assign cfg_ch.ready = (state_r == knn_pkg::ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= knn_pkg::K_W'(1);
    end else if (cfg_fire) begin
      k_r <= cfg_ch.data.k_in_use;
    end
  end

  // Zero acts as one; anything above the chain length acts as the length.
  always_comb begin
    if (k_r == '0) begin
      k_eff = knn_pkg::K_W'(1);
    end else if (32'(k_r) > MAX_NEIGHBORS) begin
      k_eff = knn_pkg::K_W'(MAX_NEIGHBORS);
    end else begin
      k_eff = k_r;
    end
  end

  assign cand.distance = in_ch.data.cand_distance;
  assign cand.label    = in_ch.data.cand_label;
  assign ctl.load      = in_fire;
  assign ctl.first     = in_ch.data.first_of_set;
  assign ctl.emit      = (state_r == knn_pkg::ST_EMIT) && out_free;

  // The chain of cells. Insertion data flows toward the tail; during a
  // readout entries flow toward the head, and the last active place takes
  // the head entry so the list is restored after k steps.
  for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
    logic            hit_in_w;
    knn_pkg::entry_t prev_w;
    knn_pkg::entry_t next_w;

    if (i == 0) begin : g_head
      assign hit_in_w = 1'b0;
      assign prev_w   = cand;
    end else begin : g_body
      assign hit_in_w = stat[i-1].hit_out;
      assign prev_w   = eff_entry[i-1];
    end

    if (i == MAX_NEIGHBORS - 1) begin : g_tail
      assign next_w = entry[0];
    end else begin : g_mid
      assign next_w = entry[i+1];
    end

    knn_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .active     (32'(k_eff) > 32'(i)),
      .is_wrap    (32'(k_eff) == 32'(i + 1)),
      .cand       (cand),
      .hit_in     (hit_in_w),
      .prev_eff   (prev_w),
      .next_entry (next_w),
      .head_entry (entry[0]),
      .eff_entry  (eff_entry[i]),
      .entry      (entry[i]),
      .stat       (stat[i])
    );

    assign hit_here[i] = stat[i].hit_here;
  end

  // At most one cell is the insertion place; with none, the candidate is
  // dropped and the report carries k.
  always_comb begin
    place_enc = '0;
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      if (hit_here[i]) begin
        place_enc = place_enc | knn_pkg::POS_W'(i);
      end
    end
  end

  assign place     = (|hit_here) ? place_enc : knn_pkg::POS_W'(k_eff);
  assign emit_last = (emit_idx_r == knn_pkg::POS_W'(k_eff - knn_pkg::K_W'(1)));

  // Sequencer: the report goes out on acceptance, the entries follow from
  // the head cell while the chain rotates.
  always_comb begin
    state_nxt     = state_r;
    emit_idx_nxt  = emit_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      knn_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind         = knn_pkg::KIND_REPORT;
          out_data_nxt.position     = place;
          out_data_nxt.out_distance = '0;
          out_data_nxt.out_label    = '0;
          out_data_nxt.last_result  = !in_ch.data.last_of_set;
          if (in_ch.data.last_of_set) begin
            state_nxt    = knn_pkg::ST_EMIT;
            emit_idx_nxt = '0;
          end
        end
      end
      knn_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind         = knn_pkg::KIND_ENTRY;
          out_data_nxt.position     = emit_idx_r;
          out_data_nxt.out_distance = entry[0].distance;
          out_data_nxt.out_label    = entry[0].label;
          out_data_nxt.last_result  = emit_last;
          if (emit_last) begin
            state_nxt = knn_pkg::ST_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + knn_pkg::POS_W'(1);
          end
        end
      end
      default: begin
        state_nxt = knn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= knn_pkg::ST_IDLE;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      emit_idx_r  <= emit_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // The insertion place is unique.
  a_place_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_here))
    else $error("more than one cell claims the insertion place");

  // A last-of-set item starts a readout behind its pending report.
  a_last_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.data.last_of_set) |=> (state_r == knn_pkg::ST_EMIT && out_valid_r))
    else $error("readout did not start after a last-of-set item");

  // The readout index never runs past the kept entries.
  a_emit_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == knn_pkg::ST_EMIT) |-> (32'(emit_idx_r) < 32'(k_eff)))
    else $error("readout index beyond the kept entries");

  // During a readout a result is always pending.
  a_emit_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == knn_pkg::ST_EMIT) |-> out_valid_r)
    else $error("readout in progress without a pending result");

endmodule

// File: rtl/knn_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_cell: one place of the sorted neighbor list
// Compares the candidate with its entry, takes the candidate, its left
// neighbor's entry or keeps its own on an insertion, and takes its right neighbor's entry
// (or the head's, at the last active place) while the list is read out.
// ----------------------------------------------------------------------------
module knn_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  knn_pkg::cell_ctl_t ctl,
  input  logic               active,
  input  logic               is_wrap,
  input  knn_pkg::entry_t    cand,
  input  logic               hit_in,
  input  knn_pkg::entry_t    prev_eff,
  input  knn_pkg::entry_t    next_entry,
  input  knn_pkg::entry_t    head_entry,
  output knn_pkg::entry_t    eff_entry,
  output knn_pkg::entry_t    entry,
  output knn_pkg::cell_stat_t stat
);

  knn_pkg::entry_t entry_r;
  knn_pkg::entry_t entry_nxt;
  logic            lt;

  // A first-of-set item sees a cleared list.
  always_comb begin
    if (ctl.first) begin
      eff_entry.distance = knn_pkg::DIST_INF;
      eff_entry.label    = knn_pkg::LABEL_NONE;
    end else begin
      eff_entry = entry_r;
    end
  end

  assign lt            = active && (cand.distance < eff_entry.distance);
  assign stat.hit_out  = hit_in | lt;
  assign stat.hit_here = lt & ~hit_in;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load) begin
      if (active && hit_in) begin
        entry_nxt = prev_eff;
      end else if (lt) begin
        entry_nxt = cand;
      end else begin
        entry_nxt = eff_entry;
      end
    end else if (ctl.emit && active) begin
      entry_nxt = is_wrap ? head_entry : next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.distance <= knn_pkg::DIST_INF;
      entry_r.label    <= knn_pkg::LABEL_NONE;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the k-nearest sorted insertion list
// Streams candidate items into the block, keeps its own sorted list of the
// kept neighbors, and checks every insertion report and every list entry
// that the block sends back. A short directed table is walked first, then
// random sets of candidates follow, with random idling on both sides and
// the list size register rewritten between sets.
// ----------------------------------------------------------------------------
module tb_top;
  import knn_pkg::*;

  localparam int MAX_K        = 16;
  localparam int RANDOM_ITEMS = 215;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 38;

  // Each directed row either writes the list size or sends one candidate.
  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    in_payload_t      cand;
    logic [K_W-1:0]   k_value;
    bit               typed;     // expected report position given below
    logic [POS_W-1:0] typed_pos;
  } stim_row_t;

  logic clk;
  logic rst_n;

  knn_stream_if #(.payload_t(in_payload_t))  in_ch ();
  knn_stream_if #(.payload_t(out_payload_t)) out_ch ();
  knn_stream_if #(.payload_t(cfg_payload_t)) cfg_ch ();

  k_nearest_sorted_insert_top #(
    .MAX_NEIGHBORS(MAX_K)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Local copy of the kept list and of the list size register. All places
  // are kept, also those beyond the current k, because a later, larger k
  // brings them back into view.
  logic [DIST_W-1:0]         kept_dist  [MAX_K];
  logic signed [LABEL_W-1:0] kept_label [MAX_K];
  logic [K_W-1:0]            k_setting;

  // Results still owed by the block, oldest first.
  out_payload_t awaited_results[$];

  stim_row_t stim_rows[$];
  int        error_count;
  int        quiet_cycles;
  bit        calm;   // when set, neither side idles

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Inserts one accepted candidate into the local list and queues the
  // results that the block owes for it: one report, and the whole active
  // list when the candidate closes its set.
  function automatic void insert_candidate(input in_payload_t cand);
    int           k_eff;
    int           place;
    out_payload_t res;
    k_eff = (k_setting == 0) ? 1 : ((k_setting > MAX_K) ? MAX_K : int'(k_setting));
    if (cand.first_of_set) begin
      for (int i = 0; i < MAX_K; i++) begin
        kept_dist[i]  = DIST_INF;
        kept_label[i] = LABEL_NONE;
      end
    end
    // Ties go behind the entries already kept; infinity never finds a place.
    place = 0;
    while (place < k_eff && !(cand.cand_distance < kept_dist[place])) place++;
    if (place < k_eff) begin
      for (int j = k_eff - 1; j > place; j--) begin
        kept_dist[j]  = kept_dist[j-1];
        kept_label[j] = kept_label[j-1];
      end
      kept_dist[place]  = cand.cand_distance;
      kept_label[place] = cand.cand_label;
    end
    res             = '0;
    res.kind        = KIND_REPORT;
    res.position    = POS_W'(place);
    res.last_result = !cand.last_of_set;
    awaited_results.push_back(res);
    if (cand.last_of_set) begin
      for (int j = 0; j < k_eff; j++) begin
        res.kind         = KIND_ENTRY;
        res.position     = POS_W'(j);
        res.out_distance = kept_dist[j];
        res.out_label    = kept_label[j];
        res.last_result  = (j == k_eff - 1);
        awaited_results.push_back(res);
      end
    end
  endfunction

  function automatic stim_row_t item_row(input logic [DIST_W-1:0] distance,
                                         input logic signed [LABEL_W-1:0] label,
                                         input logic first, input logic last,
                                         input bit typed, input int pos);
    stim_row_t row;
    row.kind               = ROW_ITEM;
    row.cand.cand_distance = distance;
    row.cand.cand_label    = label;
    row.cand.first_of_set  = first;
    row.cand.last_of_set   = last;
    row.k_value            = '0;
    row.typed              = typed;
    row.typed_pos          = POS_W'(pos);
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input int k);
    stim_row_t row;
    row         = item_row('0, '0, 1'b0, 1'b0, 1'b0, 0);
    row.kind    = ROW_CFG;
    row.k_value = K_W'(k);
    return row;
  endfunction

  // Called at a falling edge. Optionally idles first, then holds the item
  // until the block takes it, and returns at the falling edge after that.
  // Valid is only ever lowered inside the idle loop, so it never gets two
  // updates in one time step.
  task automatic send_candidate(input in_payload_t cand, input bit typed,
                                input logic [POS_W-1:0] typed_pos);
    int slot;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= cand;
    do @(posedge clk); while (!in_ch.ready);
    slot = awaited_results.size();
    insert_candidate(cand);
    // A typed position replaces the computed one, so the block is held to
    // the value written in the table.
    if (typed) awaited_results[slot].position = typed_pos;
    @(negedge clk);
  endtask

  // The list size may only change while the block is idle, so the sender
  // stops and waits for every owed result before the write.
  task automatic write_k(input logic [K_W-1:0] k);
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.data.k_in_use  <= k;
    do @(posedge clk); while (!cfg_ch.ready);
    k_setting = k;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Receiver: decides at each falling edge whether to take a result at the
  // next rising edge.
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Every accepted result is compared field by field with the oldest one
  // still owed.
  always @(posedge clk) begin : check_results
    out_payload_t want;
    out_payload_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (awaited_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result kind=%0d pos=%0d dist=%h label=%0d last=%0d",
                 $time, got.kind, got.position, got.out_distance, got.out_label,
                 got.last_result);
      end else begin
        want = awaited_results.pop_front();
        if (got.kind !== want.kind || got.position !== want.position ||
            got.out_distance !== want.out_distance ||
            got.out_label !== want.out_label ||
            got.last_result !== want.last_result) begin
          error_count++;
          $display("%0t: result mismatch, expected kind=%0d pos=%0d dist=%h label=%0d last=%0d",
                   $time, want.kind, want.position, want.out_distance, want.out_label,
                   want.last_result);
          $display("%0t:                    actual kind=%0d pos=%0d dist=%h label=%0d last=%0d",
                   $time, got.kind, got.position, got.out_distance, got.out_label,
                   got.last_result);
        end
      end
    end
  end

  // Watchdog: a long run of cycles in which no channel moves an item means
  // the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_payload_t    cand;
    logic [K_W-1:0] k_pick;
    int             items_sent;
    int             set_count;
    int             set_len;
    int             shape;

    error_count   = 0;
    quiet_cycles  = 0;
    calm          = 1'b0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;

    // State right after reset, mirrored locally.
    k_setting = K_W'(1);
    for (int i = 0; i < MAX_K; i++) begin
      kept_dist[i]  = DIST_INF;
      kept_label[i] = LABEL_NONE;
    end

    // Directed table. Positions are typed where they follow at once from
    // the reset state, the extreme distances or a clamped list size.
    // With k of one after reset, an empty list takes any finite distance.
    stim_rows.push_back(item_row(32'd100, 16'sd5, 1'b0, 1'b1, 1'b1, 0));
    // Infinity is dropped even into a freshly cleared list; both flags set.
    stim_rows.push_back(item_row(DIST_INF, 16'sd7, 1'b1, 1'b1, 1'b1, 1));
    stim_rows.push_back(cfg_row(16));
    stim_rows.push_back(item_row(32'd0, LABEL_NONE, 1'b1, 1'b0, 1'b1, 0));
    // An equal distance goes behind the one already kept.
    stim_rows.push_back(item_row(32'd0, 16'sh7FFF, 1'b0, 1'b0, 1'b1, 1));
    stim_rows.push_back(item_row(32'hFFFF_FFFE, 16'sd3, 1'b0, 1'b0, 1'b1, 2));
    stim_rows.push_back(item_row(DIST_INF, 16'sd4, 1'b0, 1'b0, 1'b1, 16));
    stim_rows.push_back(item_row(32'd50, 16'sd9, 1'b0, 1'b0, 1'b0, 0));
    stim_rows.push_back(item_row(32'd50, 16'sd10, 1'b0, 1'b1, 1'b0, 0));
    // A size of zero acts as one; the head already holds zero.
    stim_rows.push_back(cfg_row(0));
    stim_rows.push_back(item_row(32'd20, 16'sd1, 1'b0, 1'b1, 1'b1, 1));
    // A size above the maximum acts as the maximum, and the places beyond
    // the old size come back into view untouched.
    stim_rows.push_back(cfg_row(31));
    stim_rows.push_back(item_row(32'd1, 16'sd2, 1'b0, 1'b1, 1'b0, 0));
    stim_rows.push_back(cfg_row(17));
    stim_rows.push_back(item_row(32'hAAAA_AAAA, 16'sh5555, 1'b1, 1'b1, 1'b1, 0));
    stim_rows.push_back(cfg_row(3));
    stim_rows.push_back(item_row(32'h5555_5555, 16'sh2AAA, 1'b1, 1'b0, 1'b1, 0));
    stim_rows.push_back(item_row(32'hAAAA_AAAA, 16'sd1, 1'b0, 1'b0, 1'b1, 1));
    stim_rows.push_back(item_row(32'hFFFF_FFFE, 16'sd2, 1'b0, 1'b1, 1'b1, 2));

    // Synchronous reset, released at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[r]) begin
      if (stim_rows[r].kind == ROW_CFG) begin
        write_k(stim_rows[r].k_value);
      end else begin
        send_candidate(stim_rows[r].cand, stim_rows[r].typed, stim_rows[r].typed_pos);
      end
    end

    // Random sets. Most are well formed, so that lists fill up and get
    // read out; a few carry random flags or are left open. Small distances
    // make ties common, and infinity and its neighbor show up often.
    items_sent = 0;
    set_count  = 0;
    while (items_sent < RANDOM_ITEMS) begin
      calm = (set_count >= 8 && set_count < 14);
      if (set_count % 4 == 3) begin
        case ($urandom_range(0, 5))
          0:       k_pick = K_W'(0);
          1:       k_pick = K_W'(1);
          2:       k_pick = K_W'(16);
          3:       k_pick = K_W'(17);
          4:       k_pick = K_W'(31);
          default: k_pick = K_W'($urandom_range(0, 31));
        endcase
        write_k(k_pick);
      end
      set_len = $urandom_range(1, 20);
      shape   = $urandom_range(0, 9);
      for (int i = 0; i < set_len; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: cand.cand_distance = DIST_W'($urandom_range(0, 15));
          4, 5, 6:    cand.cand_distance = $urandom;
          7:          cand.cand_distance = DIST_INF;
          8:          cand.cand_distance = DIST_INF - 1;
          default:    cand.cand_distance = DIST_W'($urandom_range(0, 1000));
        endcase
        cand.cand_label = ($urandom_range(0, 9) == 0) ? LABEL_NONE
                                                      : LABEL_W'($urandom_range(0, 32767));
        case (shape)
          0: begin
            // Noise: flags at random anywhere in the set.
            cand.first_of_set = $urandom_range(0, 1);
            cand.last_of_set  = $urandom_range(0, 1);
          end
          1: begin
            // Broken set: may continue the previous list and never closes.
            cand.first_of_set = (i == 0) && $urandom_range(0, 1);
            cand.last_of_set  = 1'b0;
          end
          default: begin
            cand.first_of_set = (i == 0);
            cand.last_of_set  = (i == set_len - 1);
          end
        endcase
        send_candidate(cand, 1'b0, '0);
        items_sent++;
      end
      set_count++;
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    // Wait for every owed result, then watch a little longer for extras.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
